// ----- design/wes_pkg.sv -----
// Shared widths, constants and word types for the wave equation stencil.
`default_nettype none

package wes_pkg;

  localparam int MAX_GRID = 1024;
  localparam int MIN_GRID = 3;
  localparam int DATA_W   = 32;
  localparam int COEFF_W  = 16;

  localparam int GRID_W  = $clog2(MAX_GRID + 1);
  localparam int POS_W   = $clog2(MAX_GRID);
  localparam int CDEPTH  = 2 * MAX_GRID + 1;
  localparam int PDEPTH  = MAX_GRID + 1;
  localparam int CADDR_W = $clog2(CDEPTH);
  localparam int PADDR_W = $clog2(PDEPTH);

  // Laplacian, 2c - p, product, scaled term and final sum widths.
  localparam int LAP_W  = DATA_W + 4;
  localparam int DIFF_W = DATA_W + 2;
  localparam int PROD_W = LAP_W + COEFF_W + 1;
  localparam int SCL_W  = PROD_W - COEFF_W;
  localparam int SUM_W  = SCL_W + 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = COEFF_W;

  localparam logic [GRID_W-1:0]  GRID_RESET  = GRID_W'(MAX_GRID);
  localparam logic [COEFF_W-1:0] COEFF_RESET = COEFF_W'(13107);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SIZE,
    REG_WAVE_COEFF
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] curr_value;
    logic signed [DATA_W-1:0] prev_value;
  } item_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] next_value;
    logic [POS_W-1:0]         out_row;
    logic [POS_W-1:0]         out_col;
    logic                     frame_last;
  } res_word_t;

  // Position and border information of the point a word produces.
  typedef struct packed {
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             frame_last;
    logic             interior;
  } meta_t;

  // Delay-line write heads and read addresses for the current word.
  typedef struct packed {
    logic [CADDR_W-1:0] cur_wr;
    logic [CADDR_W-1:0] cur_east;
    logic [CADDR_W-1:0] cur_north;
    logic [PADDR_W-1:0] prv_wr;
    logic [PADDR_W-1:0] prv_rd;
  } addr_t;

  // The five stencil neighbors and the previous value of the center point.
  typedef struct packed {
    logic signed [DATA_W-1:0] north;
    logic signed [DATA_W-1:0] south;
    logic signed [DATA_W-1:0] west;
    logic signed [DATA_W-1:0] east;
    logic signed [DATA_W-1:0] center;
    logic signed [DATA_W-1:0] prev;
  } taps_t;

endpackage

`default_nettype wire

// ----- design/wes_ram.sv -----
// Generic single-write, single-read RAM with a registered, enabled read port.
`default_nettype none

module wes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- design/wes_pos.sv -----
// Configuration registers, raster position counters and delay-line addressing.
`default_nettype none

module wes_pos (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               accept,
  input  wire logic                               cfg_write,
  input  wire wes_pkg::cfg_reg_t                  cfg_index,
  input  wire logic [wes_pkg::CFG_DATA_W-1:0]     cfg_word,
  output logic      [wes_pkg::COEFF_W-1:0]        coeff,
  output wes_pkg::addr_t                          addr,
  output wes_pkg::meta_t                          meta
);

  logic [wes_pkg::GRID_W-1:0]  grid_size;
  logic [wes_pkg::COEFF_W-1:0] wave_coeff;
  logic [wes_pkg::POS_W-1:0]   in_row;
  logic [wes_pkg::POS_W-1:0]   in_col;
  logic [wes_pkg::CADDR_W-1:0] cur_head;
  logic [wes_pkg::PADDR_W-1:0] prv_head;

  logic [wes_pkg::GRID_W-1:0]  n_eff;
  logic [wes_pkg::GRID_W-1:0]  n_m1;
  logic [wes_pkg::GRID_W-1:0]  n_m2;
  logic [wes_pkg::GRID_W-1:0]  row_g;
  logic [wes_pkg::GRID_W-1:0]  col_g;
  logic [wes_pkg::GRID_W-1:0]  orow_g;
  logic [wes_pkg::GRID_W-1:0]  ocol_g;
  logic                        col_end;
  logic                        row_end;
  logic [wes_pkg::CADDR_W:0]   east_sum;
  logic [wes_pkg::CADDR_W:0]   north_sum;
  logic [wes_pkg::PADDR_W:0]   prv_sum;

  function automatic logic [wes_pkg::CADDR_W-1:0] cur_wrap(
    input logic [wes_pkg::CADDR_W:0] t
  );
    logic [wes_pkg::CADDR_W:0] u;
    begin
      u = t - (wes_pkg::CADDR_W + 1)'(wes_pkg::CDEPTH);
      if (t >= (wes_pkg::CADDR_W + 1)'(wes_pkg::CDEPTH)) begin
        return u[wes_pkg::CADDR_W-1:0];
      end
      return t[wes_pkg::CADDR_W-1:0];
    end
  endfunction

  function automatic logic [wes_pkg::PADDR_W-1:0] prv_wrap(
    input logic [wes_pkg::PADDR_W:0] t
  );
    logic [wes_pkg::PADDR_W:0] u;
    begin
      u = t - (wes_pkg::PADDR_W + 1)'(wes_pkg::PDEPTH);
      if (t >= (wes_pkg::PADDR_W + 1)'(wes_pkg::PDEPTH)) begin
        return u[wes_pkg::PADDR_W-1:0];
      end
      return t[wes_pkg::PADDR_W-1:0];
    end
  endfunction

  // An out-of-range grid size is clamped to the supported span.
  always_comb begin
    if (grid_size < wes_pkg::GRID_W'(wes_pkg::MIN_GRID)) begin
      n_eff = wes_pkg::GRID_W'(wes_pkg::MIN_GRID);
    end else if (grid_size > wes_pkg::GRID_W'(wes_pkg::MAX_GRID)) begin
      n_eff = wes_pkg::GRID_W'(wes_pkg::MAX_GRID);
    end else begin
      n_eff = grid_size;
    end
  end

  assign n_m1    = n_eff - wes_pkg::GRID_W'(1);
  assign n_m2    = n_eff - wes_pkg::GRID_W'(2);
  assign row_g   = wes_pkg::GRID_W'(in_row);
  assign col_g   = wes_pkg::GRID_W'(in_col);
  assign col_end = (col_g == n_m1);
  assign row_end = (row_g == n_m1);

  // The result belongs to the point N+1 raster positions behind the input.
  always_comb begin
    if (in_col != '0) begin
      orow_g = (in_row == '0) ? n_m1 : row_g - wes_pkg::GRID_W'(1);
      ocol_g = col_g - wes_pkg::GRID_W'(1);
    end else begin
      orow_g = (row_g >= wes_pkg::GRID_W'(2)) ? row_g - wes_pkg::GRID_W'(2) : row_g + n_m2;
      ocol_g = n_m1;
    end
  end

  always_comb begin
    meta.out_row    = orow_g[wes_pkg::POS_W-1:0];
    meta.out_col    = ocol_g[wes_pkg::POS_W-1:0];
    meta.frame_last = row_end && col_end;
    meta.interior   = (orow_g != '0) && (orow_g != n_m1) &&
                      (ocol_g != '0) && (ocol_g != n_m1);
  end

  // Read addresses count back from the write heads, modulo the store depth.
  assign east_sum  = {1'b0, cur_head} + (wes_pkg::CADDR_W + 1)'(wes_pkg::CDEPTH)
                     - (wes_pkg::CADDR_W + 1)'(n_eff);
  assign north_sum = {1'b0, cur_head} + (wes_pkg::CADDR_W + 1)'(wes_pkg::CDEPTH)
                     - (wes_pkg::CADDR_W + 1)'({n_eff, 1'b1});
  assign prv_sum   = {1'b0, prv_head} + (wes_pkg::PADDR_W + 1)'(wes_pkg::PDEPTH)
                     - (wes_pkg::PADDR_W + 1)'(n_eff) - (wes_pkg::PADDR_W + 1)'(1);

  always_comb begin
    addr.cur_wr    = cur_head;
    addr.cur_east  = cur_wrap(east_sum);
    addr.cur_north = cur_wrap(north_sum);
    addr.prv_wr    = prv_head;
    addr.prv_rd    = prv_wrap(prv_sum);
  end

  assign coeff = wave_coeff;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size  <= wes_pkg::GRID_RESET;
      wave_coeff <= wes_pkg::COEFF_RESET;
      in_row     <= '0;
      in_col     <= '0;
      cur_head   <= '0;
      prv_head   <= '0;
    end else begin
      if (accept) begin
        if (cur_head == wes_pkg::CADDR_W'(wes_pkg::CDEPTH - 1)) begin
          cur_head <= '0;
        end else begin
          cur_head <= cur_head + wes_pkg::CADDR_W'(1);
        end
        if (prv_head == wes_pkg::PADDR_W'(wes_pkg::PDEPTH - 1)) begin
          prv_head <= '0;
        end else begin
          prv_head <= prv_head + wes_pkg::PADDR_W'(1);
        end
      end
      // A grid size write restarts the raster position at the frame start.
      if (cfg_write && (cfg_index == wes_pkg::REG_GRID_SIZE)) begin
        in_row <= '0;
        in_col <= '0;
      end else if (accept) begin
        if (col_end) begin
          in_col <= '0;
          in_row <= row_end ? '0 : in_row + wes_pkg::POS_W'(1);
        end else begin
          in_col <= in_col + wes_pkg::POS_W'(1);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          wes_pkg::REG_GRID_SIZE: begin
            grid_size <= cfg_word[wes_pkg::GRID_W-1:0];
          end
          wes_pkg::REG_WAVE_COEFF: begin
            wave_coeff <= cfg_word[wes_pkg::COEFF_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/wes_taps.sv -----
// Delay-line memories and the short tap registers that form the stencil window.
`default_nettype none

module wes_taps (
  input  wire logic                clk,
  input  wire logic                accept,
  input  wire wes_pkg::item_word_t item_word,
  input  wire wes_pkg::addr_t      addr,
  input  wire wes_pkg::meta_t      meta,
  output wes_pkg::taps_t           taps,
  output wes_pkg::meta_t           meta_s1
);

  logic [wes_pkg::DATA_W-1:0] east_rd;
  logic [wes_pkg::DATA_W-1:0] north_rd;
  logic [wes_pkg::DATA_W-1:0] prev_rd;
  logic [wes_pkg::DATA_W-1:0] last_curr;
  logic [wes_pkg::DATA_W-1:0] south_s1;
  logic [wes_pkg::DATA_W-1:0] east_d1;
  logic [wes_pkg::DATA_W-1:0] east_d2;

  // Two copies of the current-value line give the east and north taps.
  wes_ram #(
    .WIDTH (wes_pkg::DATA_W),
    .DEPTH (wes_pkg::CDEPTH)
  ) u_cur_east (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (addr.cur_wr),
    .wr_data (item_word.curr_value),
    .rd_en   (accept),
    .rd_addr (addr.cur_east),
    .rd_data (east_rd)
  );

  wes_ram #(
    .WIDTH (wes_pkg::DATA_W),
    .DEPTH (wes_pkg::CDEPTH)
  ) u_cur_north (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (addr.cur_wr),
    .wr_data (item_word.curr_value),
    .rd_en   (accept),
    .rd_addr (addr.cur_north),
    .rd_data (north_rd)
  );

  wes_ram #(
    .WIDTH (wes_pkg::DATA_W),
    .DEPTH (wes_pkg::PDEPTH)
  ) u_prv (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (addr.prv_wr),
    .wr_data (item_word.prev_value),
    .rd_en   (accept),
    .rd_addr (addr.prv_rd),
    .rd_data (prev_rd)
  );

  // The center and west taps are the east taps of the two words before.
  always_ff @(posedge clk) begin
    if (accept) begin
      last_curr <= item_word.curr_value;
      south_s1  <= last_curr;
      east_d1   <= east_rd;
      east_d2   <= east_d1;
      meta_s1   <= meta;
    end
  end

  always_comb begin
    taps.north  = north_rd;
    taps.south  = south_s1;
    taps.west   = east_d2;
    taps.east   = east_rd;
    taps.center = east_d1;
    taps.prev   = prev_rd;
  end

endmodule

`default_nettype wire

// ----- design/wes_calc.sv -----
// Arithmetic pipeline: Laplacian, scaling by alpha, rounding and saturation.
`default_nettype none

module wes_calc (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         valid_s1,
  input  wire wes_pkg::taps_t               taps,
  input  wire wes_pkg::meta_t               meta_s1,
  input  wire logic [wes_pkg::COEFF_W-1:0]  coeff,
  output logic                              go_s1,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output wes_pkg::res_word_t                res_word
);

  localparam logic signed [wes_pkg::PROD_W-1:0] ROUND_HALF =
    wes_pkg::PROD_W'(1) <<< (wes_pkg::COEFF_W - 1);

  logic go_s2;
  logic go_s3;
  logic go_s4;
  logic go_res;

  logic valid_s2;
  logic valid_s3;
  logic valid_s4;

  logic signed [wes_pkg::LAP_W-1:0]  lap_s2;
  logic signed [wes_pkg::DIFF_W-1:0] diff_s2;
  wes_pkg::meta_t                    meta_s2;
  logic signed [wes_pkg::PROD_W-1:0] prod_s3;
  logic signed [wes_pkg::DIFF_W-1:0] diff_s3;
  wes_pkg::meta_t                    meta_s3;
  logic signed [wes_pkg::SCL_W-1:0]  scl_s4;
  logic signed [wes_pkg::DIFF_W-1:0] diff_s4;
  wes_pkg::meta_t                    meta_s4;

  logic signed [wes_pkg::LAP_W-1:0]  lap;
  logic signed [wes_pkg::DIFF_W-1:0] diff;
  logic signed [wes_pkg::COEFF_W:0]  coeff_s;
  logic signed [wes_pkg::PROD_W-1:0] rounded;
  logic signed [wes_pkg::SUM_W-1:0]  sum;
  logic                              ovf;
  logic signed [wes_pkg::DATA_W-1:0] sat;

  // A stage moves when the next one is empty or moving as well.
  assign go_res = !res_valid || res_ready;
  assign go_s4  = !valid_s4 || go_res;
  assign go_s3  = !valid_s3 || go_s4;
  assign go_s2  = !valid_s2 || go_s3;
  assign go_s1  = go_s2;

  assign lap = wes_pkg::LAP_W'(taps.north) + wes_pkg::LAP_W'(taps.south)
             + wes_pkg::LAP_W'(taps.west) + wes_pkg::LAP_W'(taps.east)
             - (wes_pkg::LAP_W'(taps.center) <<< 2);
  assign diff = (wes_pkg::DIFF_W'(taps.center) <<< 1) - wes_pkg::DIFF_W'(taps.prev);

  assign coeff_s = signed'({1'b0, coeff});

  // Round to nearest with ties toward plus infinity, then drop the fraction.
  assign rounded = prod_s3 + ROUND_HALF;

  assign sum = wes_pkg::SUM_W'(diff_s4) + wes_pkg::SUM_W'(scl_s4);
  assign ovf = (sum[wes_pkg::SUM_W-1:wes_pkg::DATA_W-1] != '0) &&
               (sum[wes_pkg::SUM_W-1:wes_pkg::DATA_W-1] != '1);

  always_comb begin
    if (!ovf) begin
      sat = sum[wes_pkg::DATA_W-1:0];
    end else if (sum[wes_pkg::SUM_W-1]) begin
      sat = {1'b1, {(wes_pkg::DATA_W - 1){1'b0}}};
    end else begin
      sat = {1'b0, {(wes_pkg::DATA_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s2  <= 1'b0;
      valid_s3  <= 1'b0;
      valid_s4  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (go_s2) begin
        valid_s2 <= valid_s1;
      end
      if (go_s3) begin
        valid_s3 <= valid_s2;
      end
      if (go_s4) begin
        valid_s4 <= valid_s3;
      end
      if (go_res) begin
        res_valid <= valid_s4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go_s2) begin
      lap_s2  <= lap;
      diff_s2 <= diff;
      meta_s2 <= meta_s1;
    end
    if (go_s3) begin
      prod_s3 <= lap_s2 * coeff_s;
      diff_s3 <= diff_s2;
      meta_s3 <= meta_s2;
    end
    if (go_s4) begin
      scl_s4  <= rounded[wes_pkg::PROD_W-1:wes_pkg::COEFF_W];
      diff_s4 <= diff_s3;
      meta_s4 <= meta_s3;
    end
    if (go_res) begin
      res_word.next_value <= meta_s4.interior ? sat : '0;
      res_word.out_row    <= meta_s4.out_row;
      res_word.out_col    <= meta_s4.out_col;
      res_word.frame_last <= meta_s4.frame_last;
    end
  end

endmodule

`default_nettype wire

// ----- design/wave_equation_stencil_2d.sv -----
// Top level of the streaming 2D wave equation five-point stencil.
//
//   channel  | handshake             | word
//   ---------+-----------------------+-----------------------------------------
//   item     | item_valid/item_ready | curr_value, prev_value (raster order)
//   res      | res_valid/res_ready   | next_value, out_row, out_col, frame_last
//   cfg      | cfg_valid/cfg_ready   | cfg_index, cfg_word (always ready)
//
// One word is accepted per cycle unless res_ready low holds back a full pipeline.
// The path is a delay-line read stage, Laplacian, multiply by alpha, rounding,
// and a saturating sum in the result register.
// Reset clears the counters, heads and stage valid bits; the delay lines are not cleared.
// Each stage moves when the one after it is empty or moving, so bubbles close up
// and a word can be taken while a result waits on res_ready.
`default_nettype none

module wave_equation_stencil_2d (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              item_valid,
  output logic                                   item_ready,
  input  wire wes_pkg::item_word_t               item_word,
  output logic                                   res_valid,
  input  wire logic                              res_ready,
  output wes_pkg::res_word_t                     res_word,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire wes_pkg::cfg_reg_t                 cfg_index,
  input  wire logic [wes_pkg::CFG_DATA_W-1:0]    cfg_word
);

  logic                        accept;
  logic                        valid_s1;
  logic                        go_s1;
  logic [wes_pkg::COEFF_W-1:0] coeff;
  wes_pkg::addr_t              addr;
  wes_pkg::meta_t              meta;
  wes_pkg::meta_t              meta_s1;
  wes_pkg::taps_t              taps;

  assign item_ready = !valid_s1 || go_s1;
  assign accept     = item_valid && item_ready;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s1 <= 1'b0;
    end else if (item_ready) begin
      valid_s1 <= item_valid;
    end
  end

  wes_pos u_pos (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cfg_write (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_word  (cfg_word),
    .coeff     (coeff),
    .addr      (addr),
    .meta      (meta)
  );

  wes_taps u_taps (
    .clk       (clk),
    .accept    (accept),
    .item_word (item_word),
    .addr      (addr),
    .meta      (meta),
    .taps      (taps),
    .meta_s1   (meta_s1)
  );

  wes_calc u_calc (
    .clk       (clk),
    .rst       (rst),
    .valid_s1  (valid_s1),
    .taps      (taps),
    .meta_s1   (meta_s1),
    .coeff     (coeff),
    .go_s1     (go_s1),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word)
  );

endmodule

`default_nettype wire
